### rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared constants, codes and structs of the chained hashed page table.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

    localparam int BUCKETS    = 10;
    localparam int POOL_NODES = 64;

    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 16;

    // bucket index and node index widths
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int USED_W = $clog2(POOL_NODES + 1);

    // bucket hash: reciprocal multiply for the quotient, then multiply-subtract
    // for the remainder, each a registered step; exact for every page number since
    // 2^HASH_SHIFT >= 2^PAGE_W * BUCKETS
    localparam int HASH_STEPS = 2;
    localparam int HCNT_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;
    localparam int HASH_SHIFT = PAGE_W + BKT_W;
    localparam int MUL_W      = HASH_SHIFT + 1;
    localparam int PROD_W     = PAGE_W + MUL_W;
    localparam logic [MUL_W-1:0] HASH_MUL =
        MUL_W'(((64'd1 << HASH_SHIFT) + 64'(BUCKETS - 1)) / 64'(BUCKETS));

    localparam logic CMD_INSERT    = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_HIT      = 2'd2,
        ST_FAULT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_INSERT,
        S_WALK,
        S_CMP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               link_valid;
        logic [NODE_W-1:0]  link;
    } node_t;

    typedef struct packed {
        logic    accept;
        logic    hash_step;
        logic    rd_head;
        logic    rd_link;
        logic    do_insert;
        logic    set_result;
        status_t res_code;
        logic    load_out;
    } ctl_t;

    typedef struct packed {
        logic is_translate;
        logic hash_last;
        logic pool_full;
        logic head_valid;
        logic match;
        logic link_valid;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/hpt_req_if.sv
// ----------------------------------------------------------------------------
// hpt_req_if
// Request channel: insert or translate command with its page and frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_req_if import hpt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_in;

    modport source (output valid, command, page_number, frame_in, input ready);
    modport sink   (input valid, command, page_number, frame_in, output ready);
endinterface

`default_nettype wire

### rtl/core/hpt_rsp_if.sv
// ----------------------------------------------------------------------------
// hpt_rsp_if
// Response channel: status code and translated frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_rsp_if import hpt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;

    modport source (output valid, status, frame_out, input ready);
    modport sink   (input valid, status, frame_out, output ready);
endinterface

`default_nettype wire

### rtl/core/hashed_page_table_chained_top.sv
// ----------------------------------------------------------------------------
// hashed_page_table_chained_top
// Hashed page table with chained buckets over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: command (insert or translate), page_number and
//   frame_in. rsp returns one item per request: status and frame_out.
//   The bucket is page_number modulo BUCKETS, formed by a reciprocal multiply
//   and then a multiply-subtract. An insert pushes a pool node on the head
//   of its bucket's chain; a translate walks the chain one node per cycle
//   through the pool RAM's registered read port, so the walk sets the cost
//   of a translate.
//   A translate compares up to POOL_NODES nodes of its chain, and none
//   when its bucket is empty. One item is in work at a time; req.ready
//   rises again the cycle after the result moves to the output register,
//   so a new request is taken only once the last one is done.
//   The output register holds a finished result while rsp.ready is low; the
//   next request is accepted and processed meanwhile and waits at its end
//   until the output register frees.
//   Reset empties all bucket heads and the pool count; pool contents are
//   left as they are and are only read through links that inserts wrote.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_page_table_chained_top import hpt_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hpt_req_if.sink    req,
    hpt_rsp_if.source  rsp
);

    ctl_t     ctl;
    dp_stat_t st;

    hpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .st        (st),
        .ctl       (ctl),
        .req_ready (req.ready)
    );

    hpt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .in_command (req.command),
        .in_page    (req.page_number),
        .in_frame   (req.frame_in),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_frame  (rsp.frame_out)
    );

endmodule

`default_nettype wire

### rtl/core/hpt_ram.sv
// ----------------------------------------------------------------------------
// hpt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/hpt_ctrl.sv
// ----------------------------------------------------------------------------
// hpt_ctrl
// Sequencer: accept, hash, insert or chain walk, then hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_ctrl import hpt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire dp_stat_t st,
    output ctl_t          ctl,
    output logic          req_ready
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (st.hash_last)
                begin
                    state_next = st.is_translate ? S_WALK : S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_RESULT;
            end
            S_WALK:
            begin
                state_next = st.head_valid ? S_CMP : S_RESULT;
            end
            S_CMP:
            begin
                if (st.match || !st.link_valid)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready  = 1'b1;
                ctl.accept = req_valid;
            end
            S_HASH:
            begin
                ctl.hash_step = 1'b1;
            end
            S_INSERT:
            begin
                ctl.set_result = 1'b1;
                if (st.pool_full)
                begin
                    ctl.res_code = ST_FULL;
                end
                else
                begin
                    ctl.do_insert = 1'b1;
                    ctl.res_code  = ST_INSERTED;
                end
            end
            S_WALK:
            begin
                if (st.head_valid)
                begin
                    ctl.rd_head = 1'b1;
                end
                else
                begin
                    ctl.set_result = 1'b1;
                    ctl.res_code   = ST_FAULT;
                end
            end
            S_CMP:
            begin
                priority if (st.match)
                begin
                    ctl.set_result = 1'b1;
                    ctl.res_code   = ST_HIT;
                end
                else if (st.link_valid)
                begin
                    // follow the link to the next older node
                    ctl.rd_link = 1'b1;
                end
                else
                begin
                    ctl.set_result = 1'b1;
                    ctl.res_code   = ST_FAULT;
                end
            end
            S_RESULT:
            begin
                ctl.load_out = st.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/hpt_dp.sv
// ----------------------------------------------------------------------------
// hpt_dp
// Datapath: item latch, bucket hash, bucket heads, node pool, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_dp import hpt_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctl_t         ctl,
    output dp_stat_t          st,
    input  wire logic         in_command,
    input  wire logic [PAGE_W-1:0]  in_page,
    input  wire logic [FRAME_W-1:0] in_frame,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        out_status,
    output logic [FRAME_W-1:0] out_frame
);

    logic               cmd_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [BKT_W-1:0]   rem_reg;
    logic [HCNT_W-1:0]  hcnt_reg;

    logic               head_valid_reg [BUCKETS];
    logic [NODE_W-1:0]  head_reg [BUCKETS];
    logic [USED_W-1:0]  used_reg;

    status_t            res_code_reg;
    logic [FRAME_W-1:0] res_frame_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [FRAME_W-1:0] out_frame_reg;

    logic [PAGE_W-1:0]  quot;
    logic [PAGE_W-1:0]  rem_full;
    logic [BKT_W-1:0]   rem_next;
    node_t              wr_node;
    node_t              rd_node;
    logic [$bits(node_t)-1:0] rd_word;
    logic               rd_en;
    logic [NODE_W-1:0]  rd_addr;

    assign quot     = prod_reg[HASH_SHIFT +: PAGE_W];
    assign rem_full = page_reg - quot * PAGE_W'(BUCKETS);
    assign rem_next = rem_full[BKT_W-1:0];
    assign rd_node  = node_t'(rd_word);

    assign wr_node.page       = page_reg;
    assign wr_node.frame      = frame_reg;
    assign wr_node.link_valid = head_valid_reg[rem_reg];
    assign wr_node.link       = head_reg[rem_reg];

    assign rd_en   = ctl.rd_head | ctl.rd_link;
    assign rd_addr = ctl.rd_head ? head_reg[rem_reg] : rd_node.link;

    hpt_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (POOL_NODES)
    ) u_pool (
        .clk     (clk),
        .wr_en   (ctl.do_insert),
        .wr_addr (used_reg[NODE_W-1:0]),
        .wr_data (wr_node),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_valid_reg[i] <= 1'b0;
            end
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.do_insert)
            begin
                head_valid_reg[rem_reg] <= 1'b1;
                used_reg                <= used_reg + USED_W'(1);
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= in_command;
            page_reg  <= in_page;
            frame_reg <= in_frame;
            hcnt_reg  <= '0;
        end
        if (ctl.hash_step)
        begin
            // first step forms the product, second step the remainder
            prod_reg  <= PROD_W'(page_reg) * PROD_W'(HASH_MUL);
            rem_reg   <= rem_next;
            hcnt_reg  <= hcnt_reg + HCNT_W'(1);
        end
        if (ctl.do_insert)
        begin
            head_reg[rem_reg] <= used_reg[NODE_W-1:0];
        end
        if (ctl.set_result)
        begin
            res_code_reg  <= ctl.res_code;
            res_frame_reg <= (ctl.res_code == ST_HIT) ? rd_node.frame : '0;
        end
        if (ctl.load_out)
        begin
            out_status_reg <= res_code_reg;
            out_frame_reg  <= res_frame_reg;
        end
    end

    assign st.is_translate = (cmd_reg == CMD_TRANSLATE);
    assign st.hash_last    = (hcnt_reg == HCNT_W'(HASH_STEPS - 1));
    assign st.pool_full    = (used_reg == USED_W'(POOL_NODES));
    assign st.head_valid   = head_valid_reg[rem_reg];
    assign st.match        = (rd_node.page == page_reg);
    assign st.link_valid   = rd_node.link_valid;
    assign st.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_frame  = out_frame_reg;

endmodule

`default_nettype wire
